/* src/tsm_pkg.sv */
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants for the tachometer speed meter.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int CNT_W      = 26;
    localparam int SPEED_W    = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PP_W       = 16;
    localparam int TGT_W      = 8;
    localparam int NUM_W      = 42;
    localparam int DIV_W      = NUM_W + 1;
    localparam int DCNT_W     = $clog2(DIV_W);

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
    localparam logic [33:0]        K_RPM_Q8  = 34'd15360000000;
    localparam logic [33:0]        K_RAD_Q8  = 34'd1608495439;

    localparam logic [PP_W-1:0]       PP_RST       = 16'd1;
    localparam logic [CFG_DATA_W-1:0] MAX_TIME_RST = 16'd1000;
    localparam logic [TGT_W-1:0]      TGT_RST      = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_UNITS = 2'd3;

    typedef struct packed {
        logic tick;
        logic mul;
        logic prep;
        logic div_step;
        logic load_speed;
        logic load_tmo;
    } t_dp_cmd;

    typedef struct packed {
        logic done_speed;
        logic done_tmo;
        logic div_last;
    } t_dp_stat;

endpackage

/* src/tsm_if.sv */
// ----------------------------------------------------------------------------
// tsm_if
// Valid/ready channels carrying tick items and speed results.
// ----------------------------------------------------------------------------
interface tsm_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic tach_level;

    modport source (output valid, output start_req, output tach_level, input ready);
    modport sink   (input valid, input start_req, input tach_level, output ready);
endinterface

interface tsm_out_if
    import tsm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_q8;
    logic               timed_out;

    modport source (output valid, output speed_q8, output timed_out, input ready);
    modport sink   (input valid, input speed_q8, input timed_out, output ready);
endinterface

/* src/tsm_ctrl.sv */
// ----------------------------------------------------------------------------
// tsm_ctrl
// Controller: tick acceptance, speed computation sequencing, output valid.
// ----------------------------------------------------------------------------
module tsm_ctrl
    import tsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_RUN: begin
                o_in_ready = w_out_free;
                if (i_in_valid && w_out_free) begin
                    o_cmd.tick = 1'b1;
                    if (i_stat.done_tmo) begin
                        o_cmd.load_tmo = 1'b1;
                        n_out_valid    = 1'b1;
                    end else if (i_stat.done_speed) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_speed = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* src/tsm_dp.sv */
// ----------------------------------------------------------------------------
// tsm_dp
// Datapath: config registers, edge timing counters, multiply and
// restoring divider for the speed quotient, result registers.
// ----------------------------------------------------------------------------
module tsm_dp
    import tsm_pkg::*;
#(
    parameter int TICKS_PER_MS = 1000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start_req,
    input  logic                  i_tach_level,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [SPEED_W-1:0]    o_speed_q8,
    output logic                  o_timed_out
);

    localparam int TW  = $clog2(TICKS_PER_MS + 1);
    localparam int LPW = (CFG_DATA_W + TW > CNT_W) ? CFG_DATA_W + TW : CNT_W + 1;
    localparam longint LIM_RST_FULL = longint'(MAX_TIME_RST) * longint'(TICKS_PER_MS);
    localparam logic [CNT_W-1:0] LIM_RST =
        (LIM_RST_FULL > longint'(CNT_MAX)) ? CNT_MAX : CNT_W'(LIM_RST_FULL);

    // configuration
    logic [PP_W-1:0]  r_pp;
    logic [CNT_W-1:0] r_limit;
    logic [TGT_W-1:0] r_target;
    logic             r_units;
    logic [LPW-1:0]   w_lim_prod;
    logic [CNT_W-1:0] w_lim_cap;

    // measurement state
    logic             r_busy, n_busy;
    logic             r_first, n_first;
    logic             r_prev, n_prev;
    logic [TGT_W-1:0] r_edges, n_edges;
    logic [CNT_W-1:0] r_elapsed, n_elapsed;
    logic [CNT_W-1:0] r_period, n_period;

    logic             w_edge;
    logic [TGT_W-1:0] w_tgt;
    logic [TGT_W-1:0] w_edges_inc;
    logic [CNT_W-1:0] w_el_inc;
    logic [CNT_W-1:0] w_per_inc;
    logic             w_done_speed;
    logic             w_done_tmo;

    // arithmetic
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_den;
    logic [DIV_W-1:0]  r_quo;
    logic [NUM_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_cnt;
    logic [33:0]       w_k;
    logic [CNT_W-1:0]  w_per1;
    logic [PP_W-1:0]   w_pp1;
    logic [DIV_W-1:0]  w_rem_sh;
    logic [DIV_W-1:0]  w_rem_sub;
    logic              w_ge;

    logic [SPEED_W-1:0] r_speed;
    logic               r_tmo;

    assign w_lim_prod = LPW'(i_cfg_data) * LPW'(TICKS_PER_MS);
    assign w_lim_cap  = (w_lim_prod > LPW'(CNT_MAX)) ? CNT_MAX : w_lim_prod[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp     <= PP_RST;
            r_limit  <= LIM_RST;
            r_target <= TGT_RST;
            r_units  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POLE_PAIRS:  r_pp     <= i_cfg_data;
                REG_MAX_TIME_MS: r_limit  <= w_lim_cap;
                REG_TARGET_CNT:  r_target <= i_cfg_data[TGT_W-1:0];
                REG_SPEED_UNITS: r_units  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_edge      = i_tach_level && !r_prev;
    assign w_tgt       = (r_target == '0) ? TGT_W'(1) : r_target;
    assign w_edges_inc = r_edges + TGT_W'(1);
    assign w_el_inc    = (r_elapsed == CNT_MAX) ? r_elapsed : r_elapsed + CNT_W'(1);
    assign w_per_inc   = (r_period == CNT_MAX) ? r_period : r_period + CNT_W'(1);

    // a completing edge wins over a timeout on the same tick
    assign w_done_speed = !i_start_req && r_busy && r_first && w_edge
                          && (w_edges_inc >= w_tgt);
    assign w_done_tmo   = !i_start_req && r_busy && !w_done_speed
                          && (w_el_inc >= r_limit);

    always_comb begin
        n_busy    = r_busy;
        n_first   = r_first;
        n_prev    = i_tach_level;
        n_edges   = r_edges;
        n_elapsed = r_elapsed;
        n_period  = r_period;
        if (i_start_req) begin
            n_busy    = 1'b1;
            n_first   = 1'b0;
            n_edges   = '0;
            n_elapsed = '0;
            n_period  = '0;
        end else if (r_busy) begin
            n_elapsed = w_el_inc;
            if (r_first) begin
                n_period = w_per_inc;
                if (w_edge) begin
                    n_edges = w_edges_inc;
                end
            end else if (w_edge) begin
                n_first  = 1'b1;
                n_period = '0;
            end
            if (w_done_speed || w_done_tmo) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_first   <= 1'b0;
            r_prev    <= 1'b0;
            r_edges   <= '0;
            r_elapsed <= '0;
            r_period  <= '0;
        end else if (i_cmd.tick) begin
            r_busy    <= n_busy;
            r_first   <= n_first;
            r_prev    <= n_prev;
            r_edges   <= n_edges;
            r_elapsed <= n_elapsed;
            r_period  <= n_period;
        end
    end

    assign w_k       = r_units ? K_RAD_Q8 : K_RPM_Q8;
    assign w_per1    = (r_period == '0) ? CNT_W'(1) : r_period;
    assign w_pp1     = (r_pp == '0) ? PP_W'(1) : r_pp;
    assign w_rem_sh  = {r_rem, r_quo[DIV_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num <= NUM_W'(w_k) * NUM_W'(w_tgt);
            r_den <= NUM_W'(w_per1) * NUM_W'(w_pp1);
        end
        if (i_cmd.prep) begin
            r_quo <= {1'b0, r_num} + {2'b00, r_den[NUM_W-1:1]};
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[NUM_W-1:0] : w_rem_sh[NUM_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_cnt <= r_cnt + DCNT_W'(1);
        end
        if (i_cmd.load_speed) begin
            r_speed <= (|r_quo[DIV_W-1:SPEED_W]) ? SPEED_MAX : r_quo[SPEED_W-1:0];
            r_tmo   <= 1'b0;
        end else if (i_cmd.load_tmo) begin
            r_speed <= '0;
            r_tmo   <= 1'b1;
        end
    end

    assign o_stat.done_speed = w_done_speed;
    assign o_stat.done_tmo   = w_done_tmo;
    assign o_stat.div_last   = (r_cnt == DCNT_W'(DIV_W - 1));
    assign o_speed_q8        = r_speed;
    assign o_timed_out       = r_tmo;

endmodule

/* src/tachometer_speed_meter.sv */
// Timing: a timeout result is valid the cycle after its tick; a speed result
// is valid after 1 multiply, 1 round-add, 43 bit-serial restoring divide steps
// and 1 output load, which waits until the output is free.
// Throughput: one tick per cycle, except no tick is taken while a speed result
// is being computed or while an earlier result waits and is not being taken.
// Reset: synchronous active-low; clears config to defaults, counters, output valid.
// ----------------------------------------------------------------------------
// tachometer_speed_meter
// Period-based tachometer: times rising edges over microsecond ticks and
// reports speed in rev/min or rad/s as unsigned 32.8 fixed point.
// ----------------------------------------------------------------------------
module tachometer_speed_meter
    import tsm_pkg::*;
#(
    parameter int TICKS_PER_MS = 1000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tsm_in_if.sink                i_in,
    tsm_out_if.source             o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    tsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tsm_dp #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start_req  (i_in.start_req),
        .i_tach_level (i_in.tach_level),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_speed_q8   (o_out.speed_q8),
        .o_timed_out  (o_out.timed_out)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    a_tmo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.timed_out) |-> (o_out.speed_q8 == '0))
        else $error("timeout result with nonzero speed");

    a_tmo_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.tick && w_stat.done_tmo) |=> o_out.valid)
        else $error("timeout transaction not presented");

    a_busy_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.tick && w_stat.done_speed) |=> !i_in.ready)
        else $error("input accepted during speed computation");

endmodule

/* test/tb_tachometer_speed_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tachometer_speed_meter
// Drives tick transactions (start strobe plus sampled tach level) through the
// speed meter under random source gaps and sink stalls. A tick-level model of
// the edge timing, timeout and fixed-point speed math predicts each result,
// and the scoreboard compares every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_tachometer_speed_meter;
    import tsm_pkg::*;

    localparam int          TICKS_PER_MS  = 1000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam logic [63:0] RPM_SCALE_Q8  = 64'd15360000000;   // 60 * 1e6 * 256
    localparam logic [63:0] RADS_SCALE_Q8 = 64'd1608495439;    // 2 * pi * 1e6 * 256

    typedef struct packed {
        logic [SPEED_W-1:0] speed_q8;
        logic               timed_out;
    } t_speed_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tsm_in_if  tick_if ();
    tsm_out_if speed_if ();

    tachometer_speed_meter #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_if),
        .o_out      (speed_if)
    );

    // meter model: configuration copy and measurement state
    logic [15:0]      cfg_pole_pairs;
    logic [15:0]      cfg_max_ms;
    logic [7:0]       cfg_target;
    logic             cfg_rad;
    logic             m_busy;
    logic             m_first_edge;
    logic             m_prev_level;
    logic [7:0]       m_edges;
    logic [CNT_W-1:0] m_elapsed;
    logic [CNT_W-1:0] m_period;

    t_speed_result results_due[$];

    int  errors;
    int  cycle_count;
    int  ticks_sent;
    int  live_ticks;
    int  settings_used;
    int  speeds_seen;
    int  timeouts_seen;
    int  burst_left;
    bit  gaps_on;
    bit  sink_stalls;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_tachometer_speed_meter: errors");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [7:0] edges_to_time();
        return (cfg_target == 8'd0) ? 8'd1 : cfg_target;
    endfunction

    function automatic logic [SPEED_W-1:0] speed_for(input logic [7:0] goal);
        logic [63:0] pp;
        logic [63:0] per;
        logic [63:0] scale;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        pp    = (cfg_pole_pairs == 16'd0) ? 64'd1 : {48'd0, cfg_pole_pairs};
        per   = (m_period == '0) ? 64'd1 : {{(64-CNT_W){1'b0}}, m_period};
        scale = cfg_rad ? RADS_SCALE_Q8 : RPM_SCALE_Q8;
        num   = scale * {56'd0, goal};
        den   = per * pp;
        q     = (num + (den >> 1)) / den;
        if (q > {{(64-SPEED_W){1'b0}}, SPEED_MAX})
            q = {{(64-SPEED_W){1'b0}}, SPEED_MAX};
        return q[SPEED_W-1:0];
    endfunction

    task automatic tach_model_tick(input logic strobe, input logic lvl);
        logic          rise;
        logic [7:0]    goal;
        logic [63:0]   limit;
        logic [63:0]   ms;
        t_speed_result res;
        ticks_sent++;
        if (strobe || m_busy)
            live_ticks++;
        if (strobe) begin
            m_busy       = 1'b1;
            m_first_edge = 1'b0;
            m_prev_level = lvl;
            m_edges      = 8'd0;
            m_elapsed    = '0;
            m_period     = '0;
            return;
        end
        rise         = lvl & ~m_prev_level;
        m_prev_level = lvl;
        if (!m_busy)
            return;
        m_elapsed = bump_sat(m_elapsed);
        goal      = edges_to_time();
        if (m_first_edge) begin
            m_period = bump_sat(m_period);
            if (rise) begin
                m_edges = m_edges + 8'd1;
                if (m_edges >= goal) begin
                    m_busy        = 1'b0;
                    res.speed_q8  = speed_for(goal);
                    res.timed_out = 1'b0;
                    results_due.push_back(res);
                    return;
                end
            end
        end else if (rise) begin
            m_first_edge = 1'b1;
            m_period     = '0;
        end
        ms    = {48'd0, cfg_max_ms};
        limit = ms * TICKS_PER_MS;
        if (limit > {{(64-CNT_W){1'b0}}, CNT_MAX})
            limit = {{(64-CNT_W){1'b0}}, CNT_MAX};
        if ({{(64-CNT_W){1'b0}}, m_elapsed} >= limit) begin
            m_busy        = 1'b0;
            res.speed_q8  = '0;
            res.timed_out = 1'b1;
            results_due.push_back(res);
        end
    endtask

    task automatic send_tick(input logic strobe, input logic lvl);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            if (gaps_on)
                gap = $urandom_range(1, 5);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_if.valid      <= 1'b1;
        tick_if.start_req  <= strobe;
        tick_if.tach_level <= lvl;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        tach_model_tick(strobe, lvl);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        tick_if.valid <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic apply_settings(input logic [15:0] pp, input logic [15:0] max_ms,
                                  input logic [7:0] target, input logic rad);
        wait_idle();
        cfg_beat(REG_POLE_PAIRS, pp);
        cfg_beat(REG_MAX_TIME_MS, max_ms);
        cfg_beat(REG_TARGET_CNT, {8'd0, target});
        cfg_beat(REG_SPEED_UNITS, {15'd0, rad});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_pole_pairs = pp;
        cfg_max_ms     = max_ms;
        cfg_target     = target;
        cfg_rad        = rad;
        settings_used++;
    endtask

    task automatic square_wave(input int edges, input int max_half);
        repeat (edges) begin
            repeat ($urandom_range(1, max_half)) send_tick(1'b0, 1'b0);
            repeat ($urandom_range(1, max_half)) send_tick(1'b0, 1'b1);
        end
    endtask

    task automatic random_measurement(input int max_half);
        int kind;
        int edges;
        kind  = $urandom_range(0, 9);
        edges = edges_to_time() + 1;
        if (kind <= 6) begin
            send_tick(1'b1, 1'($urandom_range(0, 1)));
            // kind 6 may leave the measurement unfinished for the next start to discard
            square_wave((kind == 6) ? $urandom_range(0, edges) : edges, max_half);
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 24))
                send_tick($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)));
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'($urandom_range(0, 1)));
        end else begin
            send_tick(1'b1, 1'($urandom_range(0, 1)));
            square_wave($urandom_range(1, edges), max_half);
            send_tick(1'b1, 1'b1);
            square_wave(edges, max_half);
        end
    endtask

    // zero time limit, zero target and zero pole pairs
    task automatic test_zero_settings();
        apply_settings(16'd0, 16'd0, 8'd0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // level already high at start is not an edge
    task automatic test_high_level_at_start();
        apply_settings(16'd0, 16'd1, 8'd0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // start while busy discards earlier edges; rad/s with maximum pole pairs
    task automatic test_restart_mid_measurement();
        apply_settings(16'd65535, 16'd1, 8'd2, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    // completing edge on the limit tick wins over the timeout
    task automatic test_limit_boundary();
        apply_settings(16'd3, 16'd1, 8'd1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        repeat (TICKS_PER_MS - 2) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int budget;
        int stop_at;
        int max_half;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    gaps_on = 1'b0; sink_stalls = 1'b0; budget = 100; max_half = 6;
                    apply_settings(16'd1, 16'd65535, 8'd1, 1'b0);
                end
                1: begin
                    gaps_on = 1'b1; sink_stalls = 1'b1; budget = 100; max_half = 12;
                    apply_settings(16'd65535, 16'd2, 8'd3, 1'b1);
                end
                2: begin
                    gaps_on = 1'b1; sink_stalls = 1'b0; budget = 40; max_half = 4;
                    apply_settings(16'($urandom_range(1, 16)), 16'd0, 8'd0,
                                   1'($urandom_range(0, 1)));
                end
                3: begin
                    gaps_on = 1'b0; sink_stalls = 1'b1; budget = 1; max_half = 1;
                    apply_settings(16'($urandom_range(1, 8)), 16'd1, 8'd255, 1'b0);
                end
                default: begin
                    gaps_on = ph[0]; sink_stalls = ph[1]; budget = 40;
                    max_half = $urandom_range(1, 16);
                    apply_settings(($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                               : 16'($urandom_range(1, 12)),
                                   16'($urandom_range(1, 3)), 8'($urandom_range(1, 6)),
                                   1'($urandom_range(0, 1)));
                end
            endcase
            stop_at = live_ticks + budget;
            while (live_ticks < stop_at)
                random_measurement(max_half);
        end
    endtask

    initial begin : sink_pattern
        int hold;
        hold = 0;
        speed_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                speed_if.ready <= 1'b0;
            end else begin
                speed_if.ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 4) == 0)
                    hold = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_speed_result want;
        if (i_rst_n && speed_if.valid === 1'b1 && speed_if.ready === 1'b1) begin
            if (speed_if.timed_out === 1'b1)
                timeouts_seen++;
            else
                speeds_seen++;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction speed_q8=%0d timed_out=%0b",
                         $time, speed_if.speed_q8, speed_if.timed_out);
            end else begin
                want = results_due.pop_front();
                if (speed_if.speed_q8 !== want.speed_q8) begin
                    errors++;
                    $display("%0t: speed_q8 expected %0d, got %0d",
                             $time, want.speed_q8, speed_if.speed_q8);
                end
                if (speed_if.timed_out !== want.timed_out) begin
                    errors++;
                    $display("%0t: timed_out expected %0b, got %0b",
                             $time, want.timed_out, speed_if.timed_out);
                end
            end
        end
    end

    initial begin
        errors        = 0;
        cycle_count   = 0;
        ticks_sent    = 0;
        live_ticks    = 0;
        settings_used = 0;
        speeds_seen   = 0;
        timeouts_seen = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        sink_stalls   = 1'b1;

        cfg_pole_pairs = 16'd1;
        cfg_max_ms     = 16'd1000;
        cfg_target     = 8'd10;
        cfg_rad        = 1'b0;
        m_busy         = 1'b0;
        m_first_edge   = 1'b0;
        m_prev_level   = 1'b0;
        m_edges        = 8'd0;
        m_elapsed      = '0;
        m_period       = '0;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = REG_POLE_PAIRS;
        i_cfg_data         = '0;
        tick_if.valid      = 1'b0;
        tick_if.start_req  = 1'b0;
        tick_if.tach_level = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_settings();
        test_high_level_at_start();
        test_restart_mid_measurement();
        test_limit_boundary();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d ticks (%0d during measurements) over %0d register settings;",
                 ticks_sent, live_ticks, settings_used);
        $display("checked %0d speed results and %0d timeouts.", speeds_seen, timeouts_seen);
        if (errors == 0) begin
            $display("tb_tachometer_speed_meter: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_tachometer_speed_meter: errors");
        end
        $finish;
    end

endmodule

/* tachometer_speed_meter.f */
src/tsm_pkg.sv
src/tsm_if.sv
src/tsm_ctrl.sv
src/tsm_dp.sv
src/tachometer_speed_meter.sv
test/tb_tachometer_speed_meter.sv
